[sv/lfpid_pkg.sv]
// Shared widths, constants, codes and stage payload types of the line follower PID controller.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package lfpid_pkg;

   // field widths
   localparam int SENSOR_COUNT = 5;
   localparam int AVERAGE_DEPTH_DEFAULT = 3;
   localparam int POS_W = 12;
   localparam int SENSOR_W = 10;
   localparam int LEVEL_W = 10;
   localparam int GAIN_W = 16;
   localparam int DRIVE_W = 8;
   localparam int END_W = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int CNT_W = $clog2(SENSOR_COUNT + 1);

   // internal widths
   localparam int SMOOTH_FRAC = 8;
   localparam int SMOOTH_W = POS_W + SMOOTH_FRAC;
   localparam int ERR_W = POS_W + 1;
   localparam int ABS_W = ERR_W - 1;
   localparam int DERIV_W = ERR_W + 1;
   localparam int INTEG_W = 16;
   localparam int CURVE_W = 6;
   localparam int P_TERM_W = ERR_W + GAIN_W;
   localparam int I_TERM_W = INTEG_W + GAIN_W;
   localparam int D_TERM_W = DERIV_W + GAIN_W;
   localparam int PID_W = 32;

   // position filter
   localparam logic [POS_W-1:0] CENTRE_POS = 12'd2000;
   localparam logic [SMOOTH_W-1:0] CENTRE_SMOOTH = {CENTRE_POS, {SMOOTH_FRAC{1'b0}}};
   localparam logic signed [ERR_W-1:0] CENTRE_ERR = 13'sd2000;
   localparam logic [7:0] SMOOTH_KEEP = 8'd179;
   localparam logic [6:0] SMOOTH_NEW = 7'd77;

   // integrator
   localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 16'sd20000;
   localparam logic [ABS_W-1:0] NEAR_CENTRE = 12'd100;
   localparam int DECAY_DIV = 5;
   localparam int DECAY_SHIFT = 20;
   localparam int DECAY_RECIP_W = 18;
   localparam logic [DECAY_RECIP_W-1:0] DECAY_RECIP =
      DECAY_RECIP_W'((2 ** DECAY_SHIFT + DECAY_DIV - 1) / DECAY_DIV);

   // curve slowdown and speed
   localparam logic [ABS_W-1:0] CURVE_ERR = 12'd500;
   localparam logic [CURVE_W-1:0] CURVE_MAX = 6'd40;
   localparam logic [CURVE_W-1:0] CURVE_STEP = 6'd2;
   localparam logic [DRIVE_W-1:0] BASE_FAST = 8'd150;
   localparam logic [DRIVE_W-1:0] BASE_SLOW = 8'd120;

   // register reset values
   localparam logic signed [GAIN_W-1:0] GAIN_P_RESET = 16'sd256;
   localparam logic signed [GAIN_W-1:0] GAIN_I_RESET = 16'sd0;
   localparam logic signed [GAIN_W-1:0] GAIN_D_RESET = 16'sd1024;
   localparam logic [LEVEL_W-1:0] CURVE_LEVEL_RESET = 10'd500;
   localparam logic [LEVEL_W-1:0] LINE_LEVEL_RESET = 10'd200;
   localparam logic [LEVEL_W-1:0] CROSS_LEVEL_RESET = 10'd700;

   typedef enum logic [END_W-1:0] {
      SEG_RUNNING  = 2'd0,
      SEG_DEAD_END = 2'd1,
      SEG_CROSSING = 2'd2
   } segment_end_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P      = 3'd0,
      CSR_GAIN_I      = 3'd1,
      CSR_GAIN_D      = 3'd2,
      CSR_CURVE_LEVEL = 3'd3,
      CSR_LINE_LEVEL  = 3'd4,
      CSR_CROSS_LEVEL = 3'd5,
      CSR_SOLVED_MODE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic [LEVEL_W-1:0]       curve_level;
      logic [LEVEL_W-1:0]       line_level;
      logic [LEVEL_W-1:0]       cross_level;
      logic                     solved_mode;
   } cfg_type;

   // captured scan; sensor 0 is the leftmost
   typedef struct packed {
      logic [POS_W-1:0]                       line_position;
      logic [SENSOR_COUNT-1:0][SENSOR_W-1:0]  sensor;
      logic                                   check_allowed;
   } scan_type;

   typedef struct packed {
      logic [POS_W-1:0] avg_pos;
      logic             curve_hit;
      segment_end_type  seg_end;
      logic             slow_approach;
   } avg_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] err;
      logic                    curve_hit;
      segment_end_type         seg_end;
      logic                    slow_approach;
   } err_type;

   typedef struct packed {
      logic signed [ERR_W-1:0]   err;
      logic signed [INTEG_W-1:0] integ;
      logic signed [DERIV_W-1:0] deriv;
      logic [DRIVE_W-1:0]        base;
      segment_end_type           seg_end;
      logic                      slow_approach;
   } pid_in_type;

   typedef struct packed {
      logic signed [P_TERM_W-1:0] p_term;
      logic signed [I_TERM_W-1:0] i_term;
      logic signed [D_TERM_W-1:0] d_term;
      logic [DRIVE_W-1:0]         base;
      segment_end_type            seg_end;
      logic                       slow_approach;
   } prod_type;

endpackage

`default_nettype wire

[sv/lfpid_if.sv]
// Request and response channel interfaces: valid/ready handshake plus payload fields.
// Depends on lfpid_pkg for the field widths.
`default_nettype none

interface lfpid_req_if;
   logic                              valid;
   logic                              ready;
   logic [lfpid_pkg::POS_W-1:0]       line_position;
   logic [lfpid_pkg::SENSOR_W-1:0]    sensor_a;
   logic [lfpid_pkg::SENSOR_W-1:0]    sensor_b;
   logic [lfpid_pkg::SENSOR_W-1:0]    sensor_c;
   logic [lfpid_pkg::SENSOR_W-1:0]    sensor_d;
   logic [lfpid_pkg::SENSOR_W-1:0]    sensor_e;
   logic                              check_allowed;

   modport source (
      output valid, line_position, sensor_a, sensor_b, sensor_c, sensor_d, sensor_e,
             check_allowed,
      input  ready
   );
   modport sink (
      input  valid, line_position, sensor_a, sensor_b, sensor_c, sensor_d, sensor_e,
             check_allowed,
      output ready
   );
endinterface

interface lfpid_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lfpid_pkg::DRIVE_W-1:0]   drive_a;
   logic [lfpid_pkg::DRIVE_W-1:0]   drive_b;
   logic [lfpid_pkg::END_W-1:0]     segment_end;
   logic                            slow_approach;

   modport source (
      output valid, drive_a, drive_b, segment_end, slow_approach,
      input  ready
   );
   modport sink (
      input  valid, drive_a, drive_b, segment_end, slow_approach,
      output ready
   );
endinterface

`default_nettype wire

[sv/lfpid_front.sv]
// Front end: request capture register, position history and running average,
// curve sensor count and dead end / intersection detection. Depends on lfpid_pkg, lfpid_if.
`default_nettype none

module lfpid_front #(
   parameter int AVERAGE_DEPTH = lfpid_pkg::AVERAGE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  lfpid_pkg::cfg_type     cfg,
   lfpid_req_if.sink              req_chan,
   output logic                   avg_valid,
   input  wire logic              avg_ready,
   output lfpid_pkg::avg_type     avg_data
);

   localparam int POS_W = lfpid_pkg::POS_W;
   localparam int SENSOR_W = lfpid_pkg::SENSOR_W;
   localparam int CNT_W = lfpid_pkg::CNT_W;
   localparam int NEAR_W = SENSOR_W + 2;
   localparam int SUM_W = POS_W + $clog2(AVERAGE_DEPTH);
   localparam int RECIP_SHIFT = SUM_W + 3;
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam int PROD_W = SUM_W + RECIP_W;
   // reciprocal of the depth, exact for every sum that fits SUM_W bits
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2 ** RECIP_SHIFT + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH);

   logic                     scan_vld_ff, scan_vld_in;
   lfpid_pkg::scan_type      scan_ff, scan_in;
   logic                     avg_vld_ff, avg_vld_in;
   lfpid_pkg::avg_type       avg_ff, avg_in;
   logic [POS_W-1:0]         ring_ff [AVERAGE_DEPTH];
   logic [POS_W-1:0]         ring_in [AVERAGE_DEPTH];
   logic [POS_W-1:0]         ring_shift [AVERAGE_DEPTH];
   logic                     scan_ready;
   logic                     avg_take;
   logic [SUM_W-1:0]         pos_sum;
   logic [PROD_W-1:0]        avg_prod;
   logic [CNT_W-1:0]         active_cnt;
   logic [SENSOR_W-1:0]      sa, sb, sc, sd, se;
   logic                     near_left, dead_end, crossing;
   lfpid_pkg::segment_end_type seg_end;

   assign avg_take   = scan_vld_ff && (!avg_vld_ff || avg_ready);
   assign scan_ready = !scan_vld_ff || avg_take;
   assign req_chan.ready = scan_ready;
   assign avg_valid = avg_vld_ff;
   assign avg_data  = avg_ff;

   always_comb begin
      scan_in.line_position = req_chan.line_position;
      scan_in.sensor[0]     = req_chan.sensor_a;
      scan_in.sensor[1]     = req_chan.sensor_b;
      scan_in.sensor[2]     = req_chan.sensor_c;
      scan_in.sensor[3]     = req_chan.sensor_d;
      scan_in.sensor[4]     = req_chan.sensor_e;
      scan_in.check_allowed = req_chan.check_allowed;
      scan_vld_in = scan_ready ? req_chan.valid : scan_vld_ff;
      avg_vld_in  = (!avg_vld_ff || avg_ready) ? scan_vld_ff : avg_vld_ff;
   end

   // history line: newest position at tap 0, sum of all taps
   always_comb begin
      ring_shift[0] = scan_ff.line_position;
      for (int i = 1; i < AVERAGE_DEPTH; i++) begin
         ring_shift[i] = ring_ff[i-1];
      end
      pos_sum = '0;
      for (int i = 0; i < AVERAGE_DEPTH; i++) begin
         pos_sum = pos_sum + SUM_W'(ring_shift[i]);
      end
      avg_prod = PROD_W'(pos_sum) * PROD_W'(RECIP);
   end

   // sensor pattern decisions
   always_comb begin
      sa = scan_ff.sensor[0];
      sb = scan_ff.sensor[1];
      sc = scan_ff.sensor[2];
      sd = scan_ff.sensor[3];
      se = scan_ff.sensor[4];
      active_cnt = '0;
      for (int i = 0; i < lfpid_pkg::SENSOR_COUNT; i++) begin
         active_cnt = active_cnt + CNT_W'(scan_ff.sensor[i] > cfg.curve_level);
      end
      near_left = ({2'b00, sa} + {1'b0, sa, 1'b0}) > {1'b0, cfg.cross_level, 1'b0};
      dead_end  = scan_ff.check_allowed && (sb <= cfg.line_level) &&
                  (sc <= cfg.line_level) && (sd <= cfg.line_level);
      crossing  = scan_ff.check_allowed && !dead_end &&
                  ((sa > cfg.cross_level && (sb > cfg.line_level || se > cfg.cross_level)) ||
                   (near_left && sb > cfg.line_level) ||
                   (se > cfg.cross_level && (sd > cfg.line_level || sa > cfg.cross_level)));
      priority if (dead_end) begin
         seg_end = lfpid_pkg::SEG_DEAD_END;
      end else if (crossing) begin
         seg_end = lfpid_pkg::SEG_CROSSING;
      end else begin
         seg_end = lfpid_pkg::SEG_RUNNING;
      end
      avg_in.avg_pos       = avg_prod[RECIP_SHIFT +: POS_W];
      avg_in.curve_hit     = active_cnt >= CNT_W'(2);
      avg_in.seg_end       = seg_end;
      avg_in.slow_approach = crossing && near_left;
   end

   // advance the history with the request; a segment end restarts it
   always_comb begin
      for (int i = 0; i < AVERAGE_DEPTH; i++) begin
         if (!avg_take) begin
            ring_in[i] = ring_ff[i];
         end else if (seg_end != lfpid_pkg::SEG_RUNNING) begin
            ring_in[i] = lfpid_pkg::CENTRE_POS;
         end else begin
            ring_in[i] = ring_shift[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_vld_ff <= 1'b0;
         avg_vld_ff  <= 1'b0;
         for (int i = 0; i < AVERAGE_DEPTH; i++) begin
            ring_ff[i] <= lfpid_pkg::CENTRE_POS;
         end
      end else begin
         scan_vld_ff <= scan_vld_in;
         avg_vld_ff  <= avg_vld_in;
         for (int i = 0; i < AVERAGE_DEPTH; i++) begin
            ring_ff[i] <= ring_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && scan_ready) begin
         scan_ff <= scan_in;
      end
      if (avg_take) begin
         avg_ff <= avg_in;
      end
   end

endmodule

`default_nettype wire

[sv/lfpid_filter.sv]
// Exponential smoother of the averaged position (Q12.8) and position error stage.
// Depends on lfpid_pkg.
`default_nettype none

module lfpid_filter (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          avg_valid,
   output logic               avg_ready,
   input  lfpid_pkg::avg_type avg_data,
   output logic               err_valid,
   input  wire logic          err_ready,
   output lfpid_pkg::err_type err_data
);

   localparam int POS_W = lfpid_pkg::POS_W;
   localparam int SMOOTH_W = lfpid_pkg::SMOOTH_W;
   localparam int FRAC = lfpid_pkg::SMOOTH_FRAC;
   localparam int KEEP_W = SMOOTH_W + 8;
   localparam int NEW_W = POS_W + 7;
   localparam int MIX_W = KEEP_W + 1;

   logic                   err_vld_ff, err_vld_in;
   lfpid_pkg::err_type     err_ff, err_in;
   logic [SMOOTH_W-1:0]    smooth_ff, smooth_in;
   logic                   load;
   logic [KEEP_W-1:0]      keep_prod;
   logic [NEW_W-1:0]       new_prod;
   logic [MIX_W-1:0]       mix;
   logic [SMOOTH_W-1:0]    smooth_next;

   assign avg_ready = !err_vld_ff || err_ready;
   assign load      = avg_valid && avg_ready;
   assign err_valid = err_vld_ff;
   assign err_data  = err_ff;

   // s' = (179*s + 77*(avg<<8)) >> 8
   always_comb begin
      keep_prod   = KEEP_W'(smooth_ff) * KEEP_W'(lfpid_pkg::SMOOTH_KEEP);
      new_prod    = NEW_W'(avg_data.avg_pos) * NEW_W'(lfpid_pkg::SMOOTH_NEW);
      mix         = MIX_W'(keep_prod) + MIX_W'({new_prod, {FRAC{1'b0}}});
      smooth_next = mix[FRAC +: SMOOTH_W];
      err_in.err  = $signed({1'b0, smooth_next[SMOOTH_W-1 -: POS_W]}) - lfpid_pkg::CENTRE_ERR;
      err_in.curve_hit     = avg_data.curve_hit;
      err_in.seg_end       = avg_data.seg_end;
      err_in.slow_approach = avg_data.slow_approach;
      err_vld_in = avg_ready ? avg_valid : err_vld_ff;
      if (!load) begin
         smooth_in = smooth_ff;
      end else if (avg_data.seg_end != lfpid_pkg::SEG_RUNNING) begin
         smooth_in = lfpid_pkg::CENTRE_SMOOTH;
      end else begin
         smooth_in = smooth_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_vld_ff <= 1'b0;
         smooth_ff  <= lfpid_pkg::CENTRE_SMOOTH;
      end else begin
         err_vld_ff <= err_vld_in;
         smooth_ff  <= smooth_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff <= err_in;
      end
   end

endmodule

`default_nettype wire

[sv/lfpid_integ.sv]
// Curve slowdown, clamped and decaying integrator, derivative and base speed stage.
// Depends on lfpid_pkg.
`default_nettype none

module lfpid_integ (
   input  wire logic             clock,
   input  wire logic             reset,
   input  lfpid_pkg::cfg_type    cfg,
   input  wire logic             err_valid,
   output logic                  err_ready,
   input  lfpid_pkg::err_type    err_data,
   output logic                  pid_valid,
   input  wire logic             pid_ready,
   output lfpid_pkg::pid_in_type pid_data
);

   localparam int ERR_W = lfpid_pkg::ERR_W;
   localparam int ABS_W = lfpid_pkg::ABS_W;
   localparam int DERIV_W = lfpid_pkg::DERIV_W;
   localparam int INTEG_W = lfpid_pkg::INTEG_W;
   localparam int CURVE_W = lfpid_pkg::CURVE_W;
   localparam int DRIVE_W = lfpid_pkg::DRIVE_W;
   localparam int ISUM_W = INTEG_W + 1;
   localparam int MAG_W = INTEG_W - 1;
   localparam int DECAY_IN_W = MAG_W + 2;
   localparam int DECAY_PROD_W = DECAY_IN_W + lfpid_pkg::DECAY_RECIP_W;

   logic                      pid_vld_ff, pid_vld_in;
   lfpid_pkg::pid_in_type     pid_ff, pid_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic [CURVE_W-1:0]        curve_ff, curve_in;
   logic                      pid_load;
   logic [ABS_W-1:0]          abs_err;
   logic [CURVE_W-1:0]        curve_next;
   logic signed [ISUM_W-1:0]  isum_raw;
   logic signed [INTEG_W-1:0] isum_clamp;
   logic [MAG_W-1:0]          isum_mag;
   logic [DECAY_PROD_W-1:0]   decay_prod;
   logic [MAG_W-1:0]          decay_mag;
   logic signed [INTEG_W-1:0] integ_next;
   logic                      seg_done;

   assign err_ready = !pid_vld_ff || pid_ready;
   assign pid_load  = err_valid && err_ready;
   assign pid_valid = pid_vld_ff;
   assign pid_data  = pid_ff;
   assign seg_done  = err_data.seg_end != lfpid_pkg::SEG_RUNNING;

   always_comb begin
      abs_err = ABS_W'(err_data.err < 0 ? -err_data.err : err_data.err);

      // ramp the slowdown up on a curve, let it bleed off otherwise
      priority if (err_data.curve_hit && abs_err > lfpid_pkg::CURVE_ERR) begin
         curve_next = (curve_ff + lfpid_pkg::CURVE_STEP > lfpid_pkg::CURVE_MAX) ?
                      lfpid_pkg::CURVE_MAX : curve_ff + lfpid_pkg::CURVE_STEP;
      end else if (curve_ff != '0) begin
         curve_next = curve_ff - CURVE_W'(1);
      end else begin
         curve_next = curve_ff;
      end

      isum_raw = ISUM_W'(integ_ff) + ISUM_W'(err_data.err);
      priority if (isum_raw > ISUM_W'(lfpid_pkg::INTEG_LIMIT)) begin
         isum_clamp = lfpid_pkg::INTEG_LIMIT;
      end else if (isum_raw < -ISUM_W'(lfpid_pkg::INTEG_LIMIT)) begin
         isum_clamp = -lfpid_pkg::INTEG_LIMIT;
      end else begin
         isum_clamp = INTEG_W'(isum_raw);
      end

      // 4/5 decay near centre, truncated toward zero on the magnitude
      isum_mag   = MAG_W'(isum_clamp < 0 ? -isum_clamp : isum_clamp);
      decay_prod = DECAY_PROD_W'({isum_mag, 2'b00}) * DECAY_PROD_W'(lfpid_pkg::DECAY_RECIP);
      decay_mag  = decay_prod[lfpid_pkg::DECAY_SHIFT +: MAG_W];
      if (abs_err < lfpid_pkg::NEAR_CENTRE) begin
         integ_next = isum_clamp < 0 ? -$signed({1'b0, decay_mag}) : $signed({1'b0, decay_mag});
      end else begin
         integ_next = isum_clamp;
      end

      pid_in.err   = err_data.err;
      pid_in.integ = integ_next;
      pid_in.deriv = DERIV_W'(err_data.err) - DERIV_W'(prev_err_ff);
      pid_in.base  = (cfg.solved_mode ? lfpid_pkg::BASE_FAST : lfpid_pkg::BASE_SLOW) -
                     DRIVE_W'(curve_next);
      pid_in.seg_end       = err_data.seg_end;
      pid_in.slow_approach = err_data.slow_approach;

      pid_vld_in = err_ready ? err_valid : pid_vld_ff;
      if (!pid_load) begin
         integ_in    = integ_ff;
         prev_err_in = prev_err_ff;
         curve_in    = curve_ff;
      end else if (seg_done) begin
         integ_in    = '0;
         prev_err_in = '0;
         curve_in    = '0;
      end else begin
         integ_in    = integ_next;
         prev_err_in = err_data.err;
         curve_in    = curve_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_vld_ff  <= 1'b0;
         integ_ff    <= '0;
         prev_err_ff <= '0;
         curve_ff    <= '0;
      end else begin
         pid_vld_ff  <= pid_vld_in;
         integ_ff    <= integ_in;
         prev_err_ff <= prev_err_in;
         curve_ff    <= curve_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pid_load) begin
         pid_ff <= pid_in;
      end
   end

   a_clear_on_segment_end: assert property (@(posedge clock) disable iff (reset)
      (pid_load && seg_done) |=> (integ_ff == '0 && prev_err_ff == '0 && curve_ff == '0))
      else $error("loop state not cleared after segment end");

   a_state_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !pid_load |=> ($stable(integ_ff) && $stable(prev_err_ff) && $stable(curve_ff)))
      else $error("loop state moved without a request");

   a_curve_ramp_step: assert property (@(posedge clock) disable iff (reset)
      pid_load |=> (curve_ff <= $past(curve_ff) + lfpid_pkg::CURVE_STEP))
      else $error("curve slowdown jumped by more than one step");

endmodule

`default_nettype wire

[sv/lfpid_drive.sv]
// PID products, scaling, clamping to base speed and the response register.
// Depends on lfpid_pkg, lfpid_if.
`default_nettype none

module lfpid_drive (
   input  wire logic             clock,
   input  wire logic             reset,
   input  lfpid_pkg::cfg_type    cfg,
   input  wire logic             pid_valid,
   output logic                  pid_ready,
   input  lfpid_pkg::pid_in_type pid_data,
   lfpid_rsp_if.source           rsp_chan
);

   localparam int P_TERM_W = lfpid_pkg::P_TERM_W;
   localparam int I_TERM_W = lfpid_pkg::I_TERM_W;
   localparam int D_TERM_W = lfpid_pkg::D_TERM_W;
   localparam int PID_W = lfpid_pkg::PID_W;
   localparam int FRAC = lfpid_pkg::SMOOTH_FRAC;
   localparam int PIDQ_W = PID_W - FRAC;
   localparam int DRIVE_W = lfpid_pkg::DRIVE_W;
   localparam int CLAMP_W = DRIVE_W + 1;
   localparam logic signed [PID_W-1:0] ROUND_BIAS = PID_W'((2 ** FRAC) - 1);

   logic                       prod_vld_ff, prod_vld_in;
   lfpid_pkg::prod_type        prod_ff, prod_in;
   logic                       rsp_vld_ff, rsp_vld_in;
   logic [DRIVE_W-1:0]         drive_a_ff, drive_a_in;
   logic [DRIVE_W-1:0]         drive_b_ff, drive_b_in;
   lfpid_pkg::segment_end_type seg_end_ff, seg_end_in;
   logic                       slow_ff, slow_in;
   logic                       prod_load;
   logic                       rsp_take;
   logic signed [PID_W-1:0]    total;
   logic signed [PID_W-1:0]    rounded;
   logic signed [PIDQ_W-1:0]   pid_q;
   logic signed [PIDQ_W-1:0]   base_q;
   logic signed [CLAMP_W-1:0]  base_s;
   logic signed [CLAMP_W-1:0]  pid_clamp;

   assign rsp_take  = prod_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign pid_ready = !prod_vld_ff || rsp_take;
   assign prod_load = pid_valid && pid_ready;

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.drive_a       = drive_a_ff;
   assign rsp_chan.drive_b       = drive_b_ff;
   assign rsp_chan.segment_end   = seg_end_ff;
   assign rsp_chan.slow_approach = slow_ff;

   always_comb begin
      prod_in.p_term = P_TERM_W'(pid_data.err) * P_TERM_W'(cfg.gain_p);
      prod_in.i_term = I_TERM_W'(pid_data.integ) * I_TERM_W'(cfg.gain_i);
      prod_in.d_term = D_TERM_W'(pid_data.deriv) * D_TERM_W'(cfg.gain_d);
      prod_in.base          = pid_data.base;
      prod_in.seg_end       = pid_data.seg_end;
      prod_in.slow_approach = pid_data.slow_approach;
      prod_vld_in = pid_ready ? pid_valid : prod_vld_ff;
   end

   always_comb begin
      total   = PID_W'(prod_ff.p_term) + PID_W'(prod_ff.i_term) + PID_W'(prod_ff.d_term);
      // divide by 256 toward zero: bias negatives before the shift
      rounded = total + (total < 0 ? ROUND_BIAS : '0);
      pid_q   = $signed(rounded[PID_W-1:FRAC]);
      base_q  = PIDQ_W'($signed({1'b0, prod_ff.base}));
      base_s  = $signed({1'b0, prod_ff.base});
      priority if (pid_q > base_q) begin
         pid_clamp = base_s;
      end else if (pid_q < -base_q) begin
         pid_clamp = -base_s;
      end else begin
         pid_clamp = CLAMP_W'(pid_q);
      end

      if (prod_ff.seg_end != lfpid_pkg::SEG_RUNNING) begin
         drive_a_in = '0;
         drive_b_in = '0;
      end else if (pid_clamp < 0) begin
         drive_a_in = DRIVE_W'(base_s + pid_clamp);
         drive_b_in = prod_ff.base;
      end else begin
         drive_a_in = prod_ff.base;
         drive_b_in = DRIVE_W'(base_s - pid_clamp);
      end
      seg_end_in = prod_ff.seg_end;
      slow_in    = prod_ff.slow_approach;
      rsp_vld_in = (!rsp_vld_ff || rsp_chan.ready) ? prod_vld_ff : rsp_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_load) begin
         prod_ff <= prod_in;
      end
      if (rsp_take) begin
         drive_a_ff <= drive_a_in;
         drive_b_ff <= drive_b_in;
         seg_end_ff <= seg_end_in;
         slow_ff    <= slow_in;
      end
   end

   a_stop_on_segment_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && seg_end_ff != lfpid_pkg::SEG_RUNNING) |-> (drive_a_ff == '0 && drive_b_ff == '0))
      else $error("motors not stopped at segment end");

   a_slow_only_at_crossing: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && slow_ff) |-> (seg_end_ff == lfpid_pkg::SEG_CROSSING))
      else $error("slow approach without an intersection");

   a_one_wheel_at_base: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && prod_ff.seg_end == lfpid_pkg::SEG_RUNNING) |=>
         (drive_a_ff == $past(prod_ff.base) || drive_b_ff == $past(prod_ff.base)))
      else $error("neither motor runs at base speed");

endmodule

`default_nettype wire

[sv/line_follow_pid_controller_unit.sv]
// A response becomes valid once its request has passed all six register stages.
// Throughput: one request per cycle while responses are taken; smoother and integrator each
// close their loop in their own stage; a stalled response fills every stage, then blocks input.
// Reset (synchronous, active high): pipeline emptied, position history at 2000, smoother at
// 2000.0, integrator, last error and curve slowdown at 0, registers to their defaults.
// Depends on lfpid_pkg, lfpid_if and the lfpid_front/filter/integ/drive stages.
`default_nettype none

module line_follow_pid_controller_unit #(
   parameter int AVERAGE_DEPTH = lfpid_pkg::AVERAGE_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   lfpid_req_if.sink                             req_chan,
   lfpid_rsp_if.source                           rsp_chan,
   input  wire logic                             csr_wr_en,
   input  wire logic [lfpid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lfpid_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int LEVEL_W = lfpid_pkg::LEVEL_W;

   lfpid_pkg::cfg_type    cfg_ff, cfg_in;
   logic                  avg_valid, avg_ready;
   lfpid_pkg::avg_type    avg_data;
   logic                  err_valid, err_ready;
   lfpid_pkg::err_type    err_data;
   logic                  pid_valid, pid_ready;
   lfpid_pkg::pid_in_type pid_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (lfpid_pkg::csr_index_type'(csr_index))
            lfpid_pkg::CSR_GAIN_P:      cfg_in.gain_p      = $signed(csr_wdata);
            lfpid_pkg::CSR_GAIN_I:      cfg_in.gain_i      = $signed(csr_wdata);
            lfpid_pkg::CSR_GAIN_D:      cfg_in.gain_d      = $signed(csr_wdata);
            lfpid_pkg::CSR_CURVE_LEVEL: cfg_in.curve_level = csr_wdata[LEVEL_W-1:0];
            lfpid_pkg::CSR_LINE_LEVEL:  cfg_in.line_level  = csr_wdata[LEVEL_W-1:0];
            lfpid_pkg::CSR_CROSS_LEVEL: cfg_in.cross_level = csr_wdata[LEVEL_W-1:0];
            lfpid_pkg::CSR_SOLVED_MODE: cfg_in.solved_mode = csr_wdata[0];
            default: begin
               // drop writes to unused indexes
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p      <= lfpid_pkg::GAIN_P_RESET;
         cfg_ff.gain_i      <= lfpid_pkg::GAIN_I_RESET;
         cfg_ff.gain_d      <= lfpid_pkg::GAIN_D_RESET;
         cfg_ff.curve_level <= lfpid_pkg::CURVE_LEVEL_RESET;
         cfg_ff.line_level  <= lfpid_pkg::LINE_LEVEL_RESET;
         cfg_ff.cross_level <= lfpid_pkg::CROSS_LEVEL_RESET;
         cfg_ff.solved_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lfpid_front #(
      .AVERAGE_DEPTH (AVERAGE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .avg_valid (avg_valid),
      .avg_ready (avg_ready),
      .avg_data  (avg_data)
   );

   lfpid_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .avg_valid (avg_valid),
      .avg_ready (avg_ready),
      .avg_data  (avg_data),
      .err_valid (err_valid),
      .err_ready (err_ready),
      .err_data  (err_data)
   );

   lfpid_integ u_integ (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .err_valid (err_valid),
      .err_ready (err_ready),
      .err_data  (err_data),
      .pid_valid (pid_valid),
      .pid_ready (pid_ready),
      .pid_data  (pid_data)
   );

   lfpid_drive u_drive (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pid_valid (pid_valid),
      .pid_ready (pid_ready),
      .pid_data  (pid_data),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
